// ===== rtl/ntid_pkg.sv =====
package ntid_pkg;

    // table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field widths
    localparam int KEY_W  = 64;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 3;
    localparam int ECNT_W = 5;

    // operation codes, any code with bit 1 set is a search
    localparam logic [FUNC_W-1:0] FN_CREATE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
    localparam int                FN_SEARCH_BIT = 1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_CREATED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STAT_W-1:0] ST_DELETED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

    // controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              scan;
        logic              shift_init;
        logic              shift;
        logic              append;
        logic              remove;
        logic              respond;
        logic [STAT_W-1:0] code;
    } ntid_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic              match;
        logic              issued_all;
        logic              full;
        logic [FUNC_W-1:0] func;
    } ntid_sts_t;

endpackage

// ===== rtl/ntid_ram.sv =====
module ntid_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ntid_datapath.sv =====
module ntid_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ntid_pkg::ntid_cmd_t          cmd,
    input  logic [ntid_pkg::FUNC_W-1:0]  func,
    input  logic [ntid_pkg::KEY_W-1:0]   key_name,
    output ntid_pkg::ntid_sts_t          sts,
    output logic                         done,
    output logic [ntid_pkg::STAT_W-1:0]  status,
    output logic [ntid_pkg::ECNT_W-1:0]  entry_count
);
    import ntid_pkg::*;

    logic [KEY_W-1:0]  key_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  paddr_reg;
    logic              pend_reg;
    logic              done_reg;
    logic [STAT_W-1:0] status_reg;

    logic              issued_all;
    logic              issue;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [KEY_W-1:0]  wdata;
    logic [KEY_W-1:0]  rd_data;
    logic [CNT_W+ECNT_W-1:0] cnt_ext;

    assign issued_all = (idx_reg == cnt_reg);
    assign issue      = (cmd.scan || cmd.shift) && !issued_all;

    // write port: append at the count, or move an entry one place down
    always_comb
    begin
        we    = 1'b0;
        waddr = cnt_reg[IDX_W-1:0];
        wdata = key_reg;
        if (cmd.append)
        begin
            we = 1'b1;
        end
        else if (cmd.shift && pend_reg)
        begin
            we    = 1'b1;
            waddr = paddr_reg - IDX_W'(1);
            wdata = rd_data;
        end
    end

    ntid_ram #(
        .WIDTH(KEY_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (issue),
        .raddr(idx_reg[IDX_W-1:0]),
        .rdata(rd_data)
    );

    // request word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= key_name;
            func_reg <= func;
        end
    end

    // read address of the entry now in the data register
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            paddr_reg <= idx_reg[IDX_W-1:0];
        end
    end

    // scan and shift pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.shift_init)
        begin
            idx_reg  <= CNT_W'(paddr_reg) + CNT_W'(1);
            pend_reg <= 1'b0;
        end
        else if (cmd.scan || cmd.shift)
        begin
            pend_reg <= issue;
            if (issue)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.append)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        else if (cmd.remove)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // result strobe and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            status_reg <= cmd.code;
        end
    end

    assign cnt_ext = {{ECNT_W{1'b0}}, cnt_reg};

    assign sts.match      = pend_reg && (rd_data == key_reg);
    assign sts.issued_all = issued_all;
    assign sts.full       = (cnt_reg == CNT_W'(ENTRIES));
    assign sts.func       = func_reg;

    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_count = cnt_ext[ECNT_W-1:0];

endmodule

// ===== rtl/ntid_ctrl.sv =====
module ntid_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ntid_pkg::ntid_sts_t sts,
    output logic                busy,
    output ntid_pkg::ntid_cmd_t cmd
);
    import ntid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_search;
    logic   is_create;

    assign is_search = sts.func[FN_SEARCH_BIT];
    assign is_create = (sts.func == FN_CREATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencing of scan, append and shift
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_NOTFOUND;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.match)
                begin
                    if (is_search)
                    begin
                        cmd.respond = 1'b1;
                        cmd.code    = ST_FOUND;
                        state_next  = S_IDLE;
                    end
                    else if (is_create)
                    begin
                        cmd.respond = 1'b1;
                        cmd.code    = ST_PRESENT;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cmd.shift_init = 1'b1;
                        state_next     = S_SHIFT;
                    end
                end
                else if (sts.issued_all)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                    if (!is_search && is_create)
                    begin
                        if (sts.full)
                        begin
                            cmd.code = ST_FULL;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                            cmd.code   = ST_CREATED;
                        end
                    end
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.issued_all)
                begin
                    cmd.remove  = 1'b1;
                    cmd.respond = 1'b1;
                    cmd.code    = ST_DELETED;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/name_table_insert_delete_search.sv =====
// compact name table with create, delete and search
//
// request channel: func and key_name are taken at a rising edge where start
// is high and busy is low. func 0 creates, 1 deletes, 2 or 3 searches.
// result channel: done is high for one cycle with status and entry_count;
// the receiver cannot stall, so the word must be taken in that cycle.
// entry_count also shows the live count between results.
//
// timing, with n names stored and the match at position p:
// the table is read one entry a cycle through the single ram read port, so
// done is raised once the match is seen on a hit, and once all n entries
// have been read on a miss (none on an empty table). a delete then moves
// the n - p - 1 later entries down, one per cycle, before done. busy drops
// in the cycle done is high, so the next request may be accepted there.
//
// reset clears the count and the controller; the name memory is not
// cleared and is only read below the count.
module name_table_insert_delete_search (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ntid_pkg::FUNC_W-1:0]  func,
    input  logic [ntid_pkg::KEY_W-1:0]   key_name,
    output logic                         done,
    output logic [ntid_pkg::STAT_W-1:0]  status,
    output logic [ntid_pkg::ECNT_W-1:0]  entry_count
);
    import ntid_pkg::*;

    ntid_cmd_t cmd;
    ntid_sts_t sts;

    ntid_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .sts  (sts),
        .busy (busy),
        .cmd  (cmd)
    );

    ntid_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .func       (func),
        .key_name   (key_name),
        .sts        (sts),
        .done       (done),
        .status     (status),
        .entry_count(entry_count)
    );

endmodule

// ===== rtl/ntid_checker.sv =====
module ntid_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         done,
    input  logic [ntid_pkg::STAT_W-1:0]  status,
    input  logic [ntid_pkg::ECNT_W-1:0]  entry_count
);
    import ntid_pkg::*;

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted request");

    // a result word is only shown once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result strobe outside end of operation");

    // status carries a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= ST_FULL))
        else $error("undefined status code");

    // a create leaves at least one name
    a_created_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_CREATED) |-> (entry_count != '0))
        else $error("created with zero count");

    // the count only moves on a result
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(entry_count))
        else $error("count changed without a result");

endmodule

bind name_table_insert_delete_search ntid_checker u_ntid_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ntid_pkg::*;

    // search codes, bit 1 set means search
    localparam logic [FUNC_W-1:0] OP_SEARCH = 2'b10;
    localparam logic [FUNC_W-1:0] OP_SPARE  = 2'b11;
    localparam int POOL_SIZE    = 24;
    localparam int RANDOM_WORDS = 800;
    localparam int DIR_ROWS     = 26;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ECNT_W-1:0] count;
    } table_word_t;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [KEY_W-1:0]  key;
        logic              fixed;
        logic [STAT_W-1:0] status;
        logic [ECNT_W-1:0] count;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key_name;
    logic              done;
    logic [STAT_W-1:0] status;
    logic [ECNT_W-1:0] entry_count;

    // expected word typed in by the directed table, taken in place of the prediction
    logic              fixed_valid;
    table_word_t       fixed_word;

    // predictor state
    logic [KEY_W-1:0]  table_keys [ENTRIES];
    int                table_used;

    table_word_t       expected_words [$];
    int                fails;
    int                words_taken;
    int                status_seen [8];

    name_table_insert_delete_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .key_name    (key_name),
        .done        (done),
        .status      (status),
        .entry_count (entry_count)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // apply one operation to the predicted table and return the word it gives
    function automatic table_word_t table_op_result(logic [FUNC_W-1:0] op,
                                                    logic [KEY_W-1:0] key);
        table_word_t w;
        int pos;
        pos = table_used;
        for (int i = table_used - 1; i >= 0; i--)
            if (table_keys[i] == key)
                pos = i;
        if (op[FN_SEARCH_BIT])
        begin
            w.status = (pos < table_used) ? ST_FOUND : ST_NOTFOUND;
        end
        else if (op == FN_CREATE)
        begin
            if (pos < table_used)
                w.status = ST_PRESENT;
            else if (table_used >= ENTRIES)
                w.status = ST_FULL;
            else
            begin
                table_keys[table_used] = key;
                table_used++;
                w.status = ST_CREATED;
            end
        end
        else
        begin
            if (pos < table_used)
            begin
                // close the gap left by the removed name
                for (int j = pos; j < table_used - 1; j++)
                    table_keys[j] = table_keys[j + 1];
                table_used--;
                w.status = ST_DELETED;
            end
            else
                w.status = ST_NOTFOUND;
        end
        w.count = ECNT_W'(table_used);
        return w;
    endfunction

    // result check and request capture, both on the sampled pre-edge values
    always @(posedge clk)
    begin
        table_word_t exp_w;
        table_word_t pred_w;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected: status %0d, entry_count %0d",
                           status, entry_count);
                    fails++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    status_seen[exp_w.status]++;
                    if (status !== exp_w.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_w.status, status);
                        fails++;
                    end
                    if (entry_count !== exp_w.count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               exp_w.count, entry_count);
                        fails++;
                    end
                end
            end
            if (start && !busy)
            begin
                pred_w = table_op_result(func, key_name);
                expected_words.push_back(fixed_valid ? fixed_word : pred_w);
                words_taken++;
            end
        end
    end

    // present one word and hold it until taken
    task automatic send_word(logic [FUNC_W-1:0] op, logic [KEY_W-1:0] key,
                             logic fixed, table_word_t w);
        @(negedge clk);
        start = 1'b1;
        func = op;
        key_name = key;
        fixed_valid = fixed;
        fixed_word = w;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_off(int n);
        repeat (n)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        dir_row_t         dir_rows [DIR_ROWS];
        logic [KEY_W-1:0] key_pool [POOL_SIZE];
        logic [FUNC_W-1:0] op;
        logic [KEY_W-1:0] key;
        int               create_pct;
        int               burst_left;
        int               r;

        start = 1'b0;
        func = FN_CREATE;
        key_name = '0;
        fixed_valid = 1'b0;
        fixed_word = '0;
        table_used = 0;
        fails = 0;
        words_taken = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir_rows = '{
            // empty table after reset
            '{OP_SEARCH, 64'h0, 1'b1, ST_NOTFOUND, 5'd0},
            '{FN_DELETE, 64'h0, 1'b1, ST_NOTFOUND, 5'd0},
            // the empty name is an ordinary name
            '{FN_CREATE, 64'h0, 1'b1, ST_CREATED, 5'd1},
            '{FN_CREATE, 64'h0, 1'b1, ST_PRESENT, 5'd1},
            // spare code decodes as search
            '{OP_SPARE, 64'h0, 1'b1, ST_FOUND, 5'd1},
            '{FN_CREATE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_CREATED, 5'd2},
            // fill the table
            '{FN_CREATE, 64'h8000_0000_0000_0000, 1'b0, ST_CREATED, 5'd0},
            '{FN_CREATE, 64'h0000_0000_0000_0001, 1'b0, ST_CREATED, 5'd0},
            '{FN_CREATE, 64'h5555_5555_5555_5555, 1'b0, ST_CREATED, 5'd0},
            '{FN_CREATE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, ST_CREATED, 5'd0},
            '{FN_CREATE, 64'h0000_656D_6461_6572, 1'b0, ST_CREATED, 5'd0},
            '{FN_CREATE, 64'h0000_0000_0000_0061, 1'b0, ST_CREATED, 5'd0},
            '{FN_CREATE, 64'h0100_0000_0000_0000, 1'b0, ST_CREATED, 5'd0},
            '{FN_CREATE, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, ST_CREATED, 5'd0},
            '{FN_CREATE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, ST_CREATED, 5'd0},
            '{FN_CREATE, 64'h0000_0000_FFFF_FFFF, 1'b0, ST_CREATED, 5'd0},
            '{FN_CREATE, 64'hFFFF_FFFF_0000_0000, 1'b0, ST_CREATED, 5'd0},
            '{FN_CREATE, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0, ST_CREATED, 5'd0},
            '{FN_CREATE, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0, ST_CREATED, 5'd0},
            '{FN_CREATE, 64'h0000_0000_0000_0002, 1'b0, ST_CREATED, 5'd0},
            // full table: new name refused, known name still reported present
            '{FN_CREATE, 64'h0000_0000_0000_0003, 1'b1, ST_FULL, 5'd16},
            '{FN_CREATE, 64'h5555_5555_5555_5555, 1'b1, ST_PRESENT, 5'd16},
            // delete in the middle, at the front and at the end
            '{FN_DELETE, 64'h0000_656D_6461_6572, 1'b0, ST_DELETED, 5'd0},
            '{FN_DELETE, 64'h0, 1'b0, ST_DELETED, 5'd0},
            '{FN_DELETE, 64'h0000_0000_0000_0002, 1'b0, ST_DELETED, 5'd0},
            '{OP_SPARE, 64'h0000_656D_6461_6572, 1'b0, ST_NOTFOUND, 5'd0}
        };

        // directed table
        foreach (dir_rows[i])
            send_word(dir_rows[i].op, dir_rows[i].key, dir_rows[i].fixed,
                      '{dir_rows[i].status, dir_rows[i].count});

        hold_off(3);
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        // a few short names so partial-byte keys recur
        for (int i = 0; i < 6; i++)
            key_pool[i] = KEY_W'($urandom_range(1, 255)) << (8 * i);

        // random part in bursts, create bias moved every hundred words
        create_pct = 75;
        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 100 == 0 && n != 0)
            begin
                case ($urandom_range(0, 2))
                    0: create_pct = 75;
                    1: create_pct = 45;
                    default: create_pct = 15;
                endcase
            end
            if (n == RANDOM_WORDS / 2)
            begin
                // let everything drain before going on
                hold_off(1);
                wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < create_pct)
                op = FN_CREATE;
            else if (r < create_pct + (100 - create_pct) / 2)
                op = FN_DELETE;
            else if (r < 95)
                op = OP_SEARCH;
            else
                op = OP_SPARE;
            if ($urandom_range(0, 4) == 0)
                key = {$urandom, $urandom};
            else
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_word(op, key, 1'b0, '0);
            burst_left--;
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    hold_off($urandom_range(10, 40));
                else
                    hold_off($urandom_range(1, 6));
                burst_left = $urandom_range(1, 24);
            end
        end

        // drain
        hold_off(1);
        wait_drained();
        repeat (2 * ENTRIES + 8) @(posedge clk);

        $display("sent %0d words: %0d created, %0d present, %0d deleted",
                 words_taken, status_seen[ST_CREATED], status_seen[ST_PRESENT],
                 status_seen[ST_DELETED]);
        $display("  %0d not found, %0d found, %0d refused on a full table",
                 status_seen[ST_NOTFOUND], status_seen[ST_FOUND], status_seen[ST_FULL]);
        if (fails == 0)
            $display("name_table_insert_delete_search test passed");
        else
            $display("name_table_insert_delete_search test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("name_table_insert_delete_search test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ntid_pkg.sv
rtl/ntid_ram.sv
rtl/ntid_datapath.sv
rtl/ntid_ctrl.sv
rtl/name_table_insert_delete_search.sv
rtl/ntid_checker.sv
bench/tb.sv
